@@ hw/rtl/kdj_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdj_pkg
// Shared types, constants and helpers for the KDJ stochastic oscillator.
// ----------------------------------------------------------------------------
package kdj_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int POS_BITS       = 16;
   localparam int KD_BITS        = 24;
   localparam int J_BITS         = 26;
   localparam int WL_BITS        = 5;
   localparam int INIT_BITS      = 7;
   localparam int CSR_DATA_BITS  = 7;
   localparam int CSR_INDEX_BITS = 2;

   localparam int WL_RESET   = 10;
   localparam int INIT_RESET = 50;
   localparam int INIT_MAX   = 100;
   localparam int KD_LIMIT   = INIT_MAX << FRAC_BITS;

   // rsv magnitude saturates at 512 whole units
   localparam int RSV_CAP_BITS = 9;
   localparam int QUO_BITS     = FRAC_BITS + RSV_CAP_BITS + 1;
   localparam int RSV_BITS     = QUO_BITS + 1;
   localparam logic [QUO_BITS-1:0] RSV_CAP_MAG = QUO_BITS'(1) << (FRAC_BITS + RSV_CAP_BITS);

   // smoothing sum and divide by three through a reciprocal
   localparam int T_BITS        = 27;
   localparam int MUL_BITS      = 32;
   localparam int PROD_BITS     = 2 * MUL_BITS;
   localparam int RECIP3_SHIFT  = 33;
   localparam int Q3_BITS       = PROD_BITS - RECIP3_SHIFT;
   localparam logic [MUL_BITS-1:0] RECIP3 = 32'hAAAA_AAAB;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_WINDOW_LEN = 2'd0,
      REG_INITIAL_K  = 2'd1,
      REG_INITIAL_D  = 2'd2
   } kdj_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_START,
      ST_PREP,
      ST_DIV,
      ST_RSV,
      ST_K_SUM,
      ST_K_MUL,
      ST_K_WB,
      ST_D_SUM,
      ST_D_MUL,
      ST_D_WB,
      ST_FINISH
   } kdj_state_type;

   typedef struct packed {
      logic accept;
      logic scan_rd;
      logic start;
      logic prep;
      logic div_step;
      logic rsv;
      logic kd_sum;
      logic sel_d;
      logic kd_mul;
      logic k_wb;
      logic d_wb;
      logic finish;
   } kdj_cmd_type;

   typedef struct packed {
      logic enough;
      logic scan_last;
      logic flat;
      logic div_last;
      logic out_free;
   } kdj_sts_type;

   function automatic logic signed [KD_BITS-1:0] kd_from_whole(input logic [INIT_BITS-1:0] v);
      logic [INIT_BITS-1:0] c;
      c = (v > INIT_BITS'(INIT_MAX)) ? INIT_BITS'(INIT_MAX) : v;
      return KD_BITS'({c, FRAC_BITS'(0)});
   endfunction

endpackage

@@ hw/rtl/kdj_stochastic_oscillator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdj_stochastic_oscillator
// KDJ oscillator over a sliding window of signed samples, one result per
// sample, K and D in signed Q8.16, J in signed Q10.16.
// ----------------------------------------------------------------------------
// One sample is processed at a time. A sample with too little history goes
// straight to the result; a sample whose window is flat is scanned only; any
// other sample is scanned, then divided and smoothed. The window scan makes
// one history RAM read per cycle; the rsv divider retires one of its 26
// quotient bits per cycle. A finished result sits in the output register,
// so the next sample is taken while the previous result still waits to
// transfer.
module kdj_stochastic_oscillator #(
   parameter int WINDOW_MAX  = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [kdj_pkg::POS_BITS-1:0]        rsp_position,
   output logic                                rsp_produced,
   output logic                                rsp_degenerate,
   output logic signed [kdj_pkg::KD_BITS-1:0]  rsp_k_value,
   output logic signed [kdj_pkg::KD_BITS-1:0]  rsp_d_value,
   output logic signed [kdj_pkg::J_BITS-1:0]   rsp_j_value,
   input  logic                                csr_wr_en,
   input  logic [kdj_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [kdj_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import kdj_pkg::*;

   kdj_cmd_type cmd;
   kdj_sts_type sts;

   kdj_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   kdj_dp #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_sample     (req_sample),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_position   (rsp_position),
      .rsp_produced   (rsp_produced),
      .rsp_degenerate (rsp_degenerate),
      .rsp_k_value    (rsp_k_value),
      .rsp_d_value    (rsp_d_value),
      .rsp_j_value    (rsp_j_value)
   );

endmodule

@@ hw/rtl/kdj_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdj_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module kdj_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/kdj_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdj_ctrl
// Sequencer: window scan, divide, K and D smoothing, result transfer.
// ----------------------------------------------------------------------------
module kdj_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output kdj_pkg::kdj_cmd_type cmd,
   input  kdj_pkg::kdj_sts_type sts
);
   import kdj_pkg::*;

   kdj_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!sts.enough) begin
               state_in = ST_FINISH;
            end else begin
               cmd.scan_rd = 1'b1;
               if (sts.scan_last) begin
                  state_in = ST_SCAN_END;
               end
            end
         end
         ST_SCAN_END: begin
            state_in = ST_START;
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in  = sts.flat ? ST_FINISH : ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_RSV;
            end
         end
         ST_RSV: begin
            cmd.rsv  = 1'b1;
            state_in = ST_K_SUM;
         end
         ST_K_SUM: begin
            cmd.kd_sum = 1'b1;
            state_in   = ST_K_MUL;
         end
         ST_K_MUL: begin
            cmd.kd_mul = 1'b1;
            state_in   = ST_K_WB;
         end
         ST_K_WB: begin
            cmd.k_wb = 1'b1;
            state_in = ST_D_SUM;
         end
         ST_D_SUM: begin
            cmd.kd_sum = 1'b1;
            cmd.sel_d  = 1'b1;
            state_in   = ST_D_MUL;
         end
         ST_D_MUL: begin
            cmd.kd_mul = 1'b1;
            state_in   = ST_D_WB;
         end
         ST_D_WB: begin
            cmd.d_wb = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ hw/rtl/kdj_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdj_dp
// Datapath: settings, sample history, max/min scan, rsv divider,
// K and D smoothing and the result register.
// ----------------------------------------------------------------------------
module kdj_dp #(
   parameter int WINDOW_MAX  = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  kdj_pkg::kdj_cmd_type                         cmd,
   output kdj_pkg::kdj_sts_type                         sts,
   input  logic signed [SAMPLE_BITS-1:0]                req_sample,
   input  logic                                         csr_wr_en,
   input  logic [kdj_pkg::CSR_INDEX_BITS-1:0]           csr_index,
   input  logic [kdj_pkg::CSR_DATA_BITS-1:0]            csr_wdata,
   output logic                                         rsp_valid,
   input  logic                                         rsp_stall,
   output logic [kdj_pkg::POS_BITS-1:0]                 rsp_position,
   output logic                                         rsp_produced,
   output logic                                         rsp_degenerate,
   output logic signed [kdj_pkg::KD_BITS-1:0]           rsp_k_value,
   output logic signed [kdj_pkg::KD_BITS-1:0]           rsp_d_value,
   output logic signed [kdj_pkg::J_BITS-1:0]            rsp_j_value
);
   import kdj_pkg::*;

   localparam int AW     = $clog2(WINDOW_MAX);
   localparam int CW     = $clog2(WINDOW_MAX + 1);
   localparam int P_BITS = SAMPLE_BITS + 6;
   localparam int C_BITS = SAMPLE_BITS + RSV_CAP_BITS;
   localparam int DCW    = $clog2(QUO_BITS);

   // settings
   logic [WL_BITS-1:0]   wlen_ff, wlen_in;
   logic [INIT_BITS-1:0] initk_ff, initk_in;
   logic [INIT_BITS-1:0] initd_ff, initd_in;

   // item and history control
   logic signed [SAMPLE_BITS-1:0] cur_ff, cur_in;
   logic [POS_BITS-1:0]           pos_ff, pos_in;
   logic [POS_BITS-1:0]           count_ff, count_in;
   logic [AW-1:0]                 wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]                 wl_ff, wl_in;
   logic [CW-1:0]                 scan_i_ff, scan_i_in;
   logic                          cmp_en_ff, cmp_first_ff;
   logic signed [SAMPLE_BITS-1:0] mx_ff, mx_in, mn_ff, mn_in;
   logic                          started_ff, started_in;
   logic signed [KD_BITS-1:0]     k_ff, k_in, d_ff, d_in;

   // rsv divider
   logic [SAMPLE_BITS-1:0] a_ff, a_in, den_ff, den_in;
   logic                   neg_ff, neg_in, cap_ff, cap_in;
   logic [SAMPLE_BITS-1:0] rem_ff, rem_in;
   logic [QUO_BITS-1:0]    dq_ff, dq_in;
   logic [DCW-1:0]         div_cnt_ff, div_cnt_in;
   logic signed [RSV_BITS-1:0] rsv_ff, rsv_in;

   // smoothing
   logic signed [T_BITS-1:0] t_ff, t_in;
   logic                     tneg_ff, tneg_in;
   logic [Q3_BITS-1:0]       q3_ff, q3_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [POS_BITS-1:0]       rsp_pos_ff, rsp_pos_in;
   logic                      rsp_prod_ff, rsp_prod_in;
   logic                      rsp_degen_ff, rsp_degen_in;
   logic signed [KD_BITS-1:0] rsp_k_ff, rsp_k_in, rsp_d_ff, rsp_d_in;
   logic signed [J_BITS-1:0]  rsp_j_ff, rsp_j_in;

   // combinational helpers
   logic [CW-1:0]                 wl_clamp;
   logic [CW:0]                   addr_sum, addr_wrap;
   logic [AW-1:0]                 rd_addr;
   logic [SAMPLE_BITS-1:0]        rd_data;
   logic signed [SAMPLE_BITS-1:0] rd_val;
   logic signed [SAMPLE_BITS:0]   diff, span;
   logic [SAMPLE_BITS:0]          diff_abs;
   logic [P_BITS-1:0]             prod60;
   logic [SAMPLE_BITS:0]          trial;
   logic                          trial_ge;
   logic [QUO_BITS:0]             rnd;
   logic [QUO_BITS-1:0]           rsv_mag;
   logic signed [RSV_BITS-1:0]    rsv_pos;
   logic signed [T_BITS-1:0]      sum_base, sum_add;
   logic [T_BITS-1:0]             t_mag;
   logic [MUL_BITS-1:0]           mul_op;
   logic [PROD_BITS-1:0]          mul_prod;
   logic [Q3_BITS-1:0]            q3_clamp;
   logic signed [KD_BITS-1:0]     kd_mag, kd_res;
   logic signed [J_BITS-1:0]      d_ext, k_ext;

   kdj_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_history (
      .clock   (clock),
      .wr_en   (cmd.finish),
      .wr_addr (wr_ptr_ff),
      .wr_data (cur_ff),
      .rd_en   (cmd.scan_rd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      wlen_in      = wlen_ff;
      initk_in     = initk_ff;
      initd_in     = initd_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      wr_ptr_in    = wr_ptr_ff;
      wl_in        = wl_ff;
      scan_i_in    = scan_i_ff;
      mx_in        = mx_ff;
      mn_in        = mn_ff;
      started_in   = started_ff;
      k_in         = k_ff;
      d_in         = d_ff;
      a_in         = a_ff;
      den_in       = den_ff;
      neg_in       = neg_ff;
      cap_in       = cap_ff;
      rem_in       = rem_ff;
      dq_in        = dq_ff;
      div_cnt_in   = div_cnt_ff;
      rsv_in       = rsv_ff;
      t_in         = t_ff;
      tneg_in      = tneg_ff;
      q3_in        = q3_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_prod_in  = rsp_prod_ff;
      rsp_degen_in = rsp_degen_ff;
      rsp_k_in     = rsp_k_ff;
      rsp_d_in     = rsp_d_ff;
      rsp_j_in     = rsp_j_ff;

      // settings port
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_WINDOW_LEN: wlen_in  = csr_wdata[WL_BITS-1:0];
            REG_INITIAL_K:  initk_in = csr_wdata;
            REG_INITIAL_D:  initd_in = csr_wdata;
            default: begin
            end
         endcase
      end

      // window length clamped into range
      if (wlen_ff == '0) begin
         wl_clamp = CW'(1);
      end else if (32'(wlen_ff) > WINDOW_MAX) begin
         wl_clamp = CW'(WINDOW_MAX);
      end else begin
         wl_clamp = CW'(wlen_ff);
      end

      if (cmd.accept) begin
         cur_in    = req_sample;
         pos_in    = count_ff;
         wl_in     = wl_clamp;
         scan_i_in = CW'(1);
      end

      // window scan, newest first
      addr_sum  = (CW+1)'(wr_ptr_ff) + (CW+1)'(WINDOW_MAX) - (CW+1)'(scan_i_ff);
      addr_wrap = (addr_sum >= (CW+1)'(WINDOW_MAX)) ? addr_sum - (CW+1)'(WINDOW_MAX)
                                                     : addr_sum;
      rd_addr   = AW'(addr_wrap);
      if (cmd.scan_rd) begin
         scan_i_in = scan_i_ff + CW'(1);
      end

      rd_val = rd_data;
      if (cmp_en_ff) begin
         if (cmp_first_ff || rd_val > mx_ff) begin
            mx_in = rd_val;
         end
         if (cmp_first_ff || rd_val < mn_ff) begin
            mn_in = rd_val;
         end
      end

      // operands of rsv
      diff     = {cur_ff[SAMPLE_BITS-1], cur_ff} - {mn_ff[SAMPLE_BITS-1], mn_ff};
      span     = {mx_ff[SAMPLE_BITS-1], mx_ff} - {mn_ff[SAMPLE_BITS-1], mn_ff};
      diff_abs = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff) : (SAMPLE_BITS+1)'(diff);
      if (cmd.start) begin
         a_in       = diff_abs[SAMPLE_BITS-1:0];
         neg_in     = diff[SAMPLE_BITS];
         den_in     = span[SAMPLE_BITS-1:0];
         started_in = 1'b1;
         if (!started_ff) begin
            k_in = kd_from_whole(initk_ff);
            d_in = kd_from_whole(initd_ff);
         end
      end

      // times sixty, saturation test and divider load
      prod60 = {a_ff, 6'b0} - {4'b0, a_ff, 2'b0};
      if (cmd.prep) begin
         cap_in     = C_BITS'(prod60) >= {den_ff, RSV_CAP_BITS'(0)};
         rem_in     = SAMPLE_BITS'(prod60[P_BITS-1:RSV_CAP_BITS]);
         dq_in      = {prod60[RSV_CAP_BITS-1:0], (FRAC_BITS+1)'(0)};
         div_cnt_in = '0;
      end

      // restoring divide, one quotient bit a cycle
      trial    = {rem_ff, dq_ff[QUO_BITS-1]};
      trial_ge = trial >= {1'b0, den_ff};
      if (cmd.div_step) begin
         rem_in     = trial_ge ? SAMPLE_BITS'(trial - {1'b0, den_ff}) : SAMPLE_BITS'(trial);
         dq_in      = {dq_ff[QUO_BITS-2:0], trial_ge};
         div_cnt_in = div_cnt_ff + DCW'(1);
      end

      // round half up, saturate, apply sign
      rnd     = {1'b0, dq_ff} + (QUO_BITS+1)'(1);
      rsv_mag = cap_ff ? RSV_CAP_MAG : rnd[QUO_BITS:1];
      rsv_pos = {1'b0, rsv_mag};
      if (cmd.rsv) begin
         rsv_in = neg_ff ? -rsv_pos : rsv_pos;
      end

      // 2*x + y, then divide by three to nearest
      sum_base = cmd.sel_d ? T_BITS'(d_ff) : T_BITS'(k_ff);
      sum_add  = cmd.sel_d ? T_BITS'(k_ff) : T_BITS'(rsv_ff);
      if (cmd.kd_sum) begin
         t_in = (sum_base <<< 1) + sum_add;
      end

      t_mag    = t_ff[T_BITS-1] ? T_BITS'(-t_ff) : T_BITS'(t_ff);
      mul_op   = MUL_BITS'(t_mag) + MUL_BITS'(1);
      mul_prod = PROD_BITS'(mul_op) * PROD_BITS'(RECIP3);
      if (cmd.kd_mul) begin
         tneg_in = t_ff[T_BITS-1];
         q3_in   = mul_prod[PROD_BITS-1:RECIP3_SHIFT];
      end

      q3_clamp = (q3_ff > Q3_BITS'(KD_LIMIT)) ? Q3_BITS'(KD_LIMIT) : q3_ff;
      kd_mag   = KD_BITS'(q3_clamp);
      kd_res   = tneg_ff ? -kd_mag : kd_mag;
      if (cmd.k_wb) begin
         k_in = kd_res;
      end
      if (cmd.d_wb) begin
         d_in = kd_res;
      end

      // result transfer and history update
      d_ext = J_BITS'(d_ff);
      k_ext = J_BITS'(k_ff);
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = pos_ff;
         rsp_prod_in  = sts.enough;
         rsp_degen_in = sts.enough && sts.flat;
         rsp_k_in     = sts.enough ? k_ff : '0;
         rsp_d_in     = sts.enough ? d_ff : '0;
         rsp_j_in     = sts.enough ? (d_ext <<< 1) + d_ext - (k_ext <<< 1) : '0;
         wr_ptr_in    = (wr_ptr_ff == AW'(WINDOW_MAX - 1)) ? '0 : wr_ptr_ff + AW'(1);
         if (count_ff != '1) begin
            count_in = count_ff + POS_BITS'(1);
         end
      end
   end

   always_comb begin
      sts.enough    = POS_BITS'(wl_ff) < pos_ff;
      sts.scan_last = scan_i_ff == wl_ff;
      sts.flat      = mx_ff == mn_ff;
      sts.div_last  = div_cnt_ff == DCW'(QUO_BITS - 1);
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff      <= WL_BITS'(WL_RESET);
         initk_ff     <= INIT_BITS'(INIT_RESET);
         initd_ff     <= INIT_BITS'(INIT_RESET);
         count_ff     <= '0;
         wr_ptr_ff    <= '0;
         started_ff   <= 1'b0;
         cmp_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wlen_ff      <= wlen_in;
         initk_ff     <= initk_in;
         initd_ff     <= initd_in;
         count_ff     <= count_in;
         wr_ptr_ff    <= wr_ptr_in;
         started_ff   <= started_in;
         cmp_en_ff    <= cmd.scan_rd;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      pos_ff       <= pos_in;
      wl_ff        <= wl_in;
      scan_i_ff    <= scan_i_in;
      cmp_first_ff <= cmd.scan_rd && (scan_i_ff == CW'(1));
      mx_ff        <= mx_in;
      mn_ff        <= mn_in;
      k_ff         <= k_in;
      d_ff         <= d_in;
      a_ff         <= a_in;
      den_ff       <= den_in;
      neg_ff       <= neg_in;
      cap_ff       <= cap_in;
      rem_ff       <= rem_in;
      dq_ff        <= dq_in;
      div_cnt_ff   <= div_cnt_in;
      rsv_ff       <= rsv_in;
      t_ff         <= t_in;
      tneg_ff      <= tneg_in;
      q3_ff        <= q3_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_prod_ff  <= rsp_prod_in;
      rsp_degen_ff <= rsp_degen_in;
      rsp_k_ff     <= rsp_k_in;
      rsp_d_ff     <= rsp_d_in;
      rsp_j_ff     <= rsp_j_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_position   = rsp_pos_ff;
   assign rsp_produced   = rsp_prod_ff;
   assign rsp_degenerate = rsp_degen_ff;
   assign rsp_k_value    = rsp_k_ff;
   assign rsp_d_value    = rsp_d_ff;
   assign rsp_j_value    = rsp_j_ff;

endmodule

@@ hw/rtl/kdj_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdj_port_checks
// Port level checks on the result channel of the KDJ oscillator.
// ----------------------------------------------------------------------------
module kdj_port_checks (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [kdj_pkg::POS_BITS-1:0]        rsp_position,
   input logic                                rsp_produced,
   input logic                                rsp_degenerate,
   input logic signed [kdj_pkg::KD_BITS-1:0]  rsp_k_value,
   input logic signed [kdj_pkg::KD_BITS-1:0]  rsp_d_value,
   input logic signed [kdj_pkg::J_BITS-1:0]   rsp_j_value
);
   import kdj_pkg::*;

   logic signed [J_BITS-1:0] d_ext, k_ext, j_chk;

   assign d_ext = J_BITS'(rsp_d_value);
   assign k_ext = J_BITS'(rsp_k_value);
   assign j_chk = (d_ext <<< 1) + d_ext - (k_ext <<< 1);

   // stalled result holds until transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_position)
         && $stable(rsp_produced) && $stable(rsp_degenerate)
         && $stable(rsp_k_value) && $stable(rsp_d_value) && $stable(rsp_j_value))
      else $error("stalled result changed");

   // short history gives an all-zero result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_produced |-> !rsp_degenerate && rsp_k_value == '0
         && rsp_d_value == '0 && rsp_j_value == '0)
      else $error("result without update is not zero");

   // j follows k and d
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_produced |-> rsp_j_value == j_chk)
      else $error("j does not equal 3d - 2k");

   // flat window only on an update
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_produced && rsp_position != '0)
      else $error("degenerate flag without update");

endmodule

bind kdj_stochastic_oscillator kdj_port_checks u_checker (.*);
